@@ hw/rtl/discrete_laplace_probability_macros.svh @@
// Assertion macros for the discrete Laplace probability block
`ifndef DISCRETE_LAPLACE_PROBABILITY_MACROS_SVH
`define DISCRETE_LAPLACE_PROBABILITY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DLP_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("dlp: same-cycle check failed");
`define DLP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("dlp: next-cycle check failed");
`else
`define DLP_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define DLP_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ hw/rtl/dlp_pkg.sv @@
`timescale 1ns / 1ps
// Package with types, constants and tables of the discrete Laplace probability block
package dlp_pkg;
    localparam int unsigned MAX_ERROR    = 255;
    localparam int unsigned ERR_W        = 9;
    localparam int unsigned MAG_W        = 9;
    localparam int unsigned MULT_W       = 10;
    localparam int unsigned SD_W         = 16;
    localparam int unsigned SQRT2_W      = 33;
    localparam int unsigned NUM_W        = 49;
    localparam int unsigned FRAC_W       = 32;
    localparam int unsigned INT_W        = NUM_W - FRAC_W;
    localparam int unsigned EXP_N_W      = 5;
    localparam int unsigned EXP_N_MAX    = 23;
    localparam int unsigned TERM_W       = FRAC_W + 1;
    localparam int unsigned SUM_W        = FRAC_W + 2;
    localparam int unsigned EXPM1_W      = 31;
    localparam int unsigned PROB_W       = 17;
    localparam int unsigned K_W          = 4;
    localparam int unsigned LANES        = 2;
    localparam int unsigned QUOT_CELLS   = NUM_W;
    localparam int unsigned TAYLOR_TERMS = 14;
    localparam int unsigned RECIP_CELLS  = FRAC_W;
    localparam int unsigned POW_CELLS    = EXP_N_MAX;

    localparam logic [SQRT2_W-1:0] SQRT2_Q32     = 33'd6074001000;
    localparam logic [EXPM1_W-1:0] EXPM1_Q32     = 31'd1580030169;
    localparam logic [PROB_W-1:0]  PROB_ONE      = 17'd65536;
    localparam logic [SD_W-1:0]    STD_DEV_RESET = 16'd256;

    typedef struct packed {
        logic valid;
        logic oor;
        logic s_zero;
        logic a_zero;
        logic a_max;
    } dlp_ctl_t;

    typedef struct packed {
        logic [SD_W-1:0]  rem;
        logic [NUM_W-1:0] nq;
    } dlp_div_t;

    typedef struct packed {
        logic [TERM_W-1:0]  term;
        logic [SUM_W-1:0]   sum;
        logic [FRAC_W-1:0]  f;
        logic [EXP_N_W-1:0] n;
        logic               z;
    } dlp_tay_t;

    typedef struct packed {
        logic [SUM_W-1:0]   rem;
        logic [SUM_W-1:0]   sum;
        logic [FRAC_W-1:0]  q;
        logic [EXP_N_W-1:0] n;
        logic               z;
    } dlp_rcp_t;

    typedef struct packed {
        logic [FRAC_W-1:0]  e;
        logic [EXP_N_W-1:0] n;
        logic               z;
    } dlp_pow_t;

    // floor((2^33 - 1) / k): estimate within one below the true quotient
    function automatic logic [TERM_W-1:0] taylor_recip(input logic [K_W-1:0] k);
        logic [TERM_W-1:0] r;
        unique case (k)
            4'd1:    r = 33'd8589934591;
            4'd2:    r = 33'd4294967295;
            4'd3:    r = 33'd2863311530;
            4'd4:    r = 33'd2147483647;
            4'd5:    r = 33'd1717986918;
            4'd6:    r = 33'd1431655765;
            4'd7:    r = 33'd1227133513;
            4'd8:    r = 33'd1073741823;
            4'd9:    r = 33'd954437176;
            4'd10:   r = 33'd858993459;
            4'd11:   r = 33'd780903144;
            4'd12:   r = 33'd715827882;
            4'd13:   r = 33'd660764199;
            4'd14:   r = 33'd613566756;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

@@ hw/rtl/dlp_quot_cell.sv @@
`timescale 1ns / 1ps
// One restoring division step of the exponent argument, both lanes
module dlp_quot_cell (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  dlp_pkg::dlp_ctl_t                             ctl_in,
    input  logic [dlp_pkg::SD_W-1:0]                      sd_in,
    input  dlp_pkg::dlp_div_t [dlp_pkg::LANES-1:0]        lane_in,
    output dlp_pkg::dlp_ctl_t                             ctl_out,
    output logic [dlp_pkg::SD_W-1:0]                      sd_out,
    output dlp_pkg::dlp_div_t [dlp_pkg::LANES-1:0]        lane_out
);
    dlp_pkg::dlp_ctl_t                       ctl_reg;
    logic [dlp_pkg::SD_W-1:0]                sd_reg;
    dlp_pkg::dlp_div_t [dlp_pkg::LANES-1:0]  lane_reg;
    dlp_pkg::dlp_div_t [dlp_pkg::LANES-1:0]  lane_next;

    always_comb
    begin
        logic [dlp_pkg::SD_W:0] trial;
        for (int i = 0; i < dlp_pkg::LANES; i++)
        begin
            trial = {lane_in[i].rem, lane_in[i].nq[dlp_pkg::NUM_W-1]};
            if (trial >= {1'b0, sd_in})
            begin
                lane_next[i].rem = dlp_pkg::SD_W'(trial - {1'b0, sd_in});
                lane_next[i].nq  = {lane_in[i].nq[dlp_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                lane_next[i].rem = trial[dlp_pkg::SD_W-1:0];
                lane_next[i].nq  = {lane_in[i].nq[dlp_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sd_reg   <= sd_in;
        lane_reg <= lane_next;
    end

    assign ctl_out  = ctl_reg;
    assign sd_out   = sd_reg;
    assign lane_out = lane_reg;
endmodule

@@ hw/rtl/dlp_taylor_cell.sv @@
`timescale 1ns / 1ps
// One Taylor term of exp(f): multiply, divide by the term order, accumulate
module dlp_taylor_cell (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [dlp_pkg::K_W-1:0]                       k_in,
    input  dlp_pkg::dlp_ctl_t                             ctl_in,
    input  dlp_pkg::dlp_tay_t [dlp_pkg::LANES-1:0]        lane_in,
    output dlp_pkg::dlp_ctl_t                             ctl_out,
    output dlp_pkg::dlp_tay_t [dlp_pkg::LANES-1:0]        lane_out
);
    localparam int unsigned PW = dlp_pkg::FRAC_W;

    dlp_pkg::dlp_ctl_t                       ctl1_reg;
    dlp_pkg::dlp_ctl_t                       ctl2_reg;
    dlp_pkg::dlp_ctl_t                       ctl3_reg;
    dlp_pkg::dlp_tay_t [dlp_pkg::LANES-1:0]  lane1_reg;
    dlp_pkg::dlp_tay_t [dlp_pkg::LANES-1:0]  lane2_reg;
    dlp_pkg::dlp_tay_t [dlp_pkg::LANES-1:0]  lane3_reg;
    dlp_pkg::dlp_tay_t [dlp_pkg::LANES-1:0]  lane3_next;
    logic [dlp_pkg::LANES-1:0][PW-1:0]       p1_reg;
    logic [dlp_pkg::LANES-1:0][PW-1:0]       p1_next;
    logic [dlp_pkg::LANES-1:0][PW-1:0]       p2_reg;
    logic [dlp_pkg::LANES-1:0][PW-1:0]       q0_reg;
    logic [dlp_pkg::LANES-1:0][PW-1:0]       q0_next;
    logic [dlp_pkg::TERM_W-1:0]              recip;

    assign recip = dlp_pkg::taylor_recip(k_in);

    always_comb
    begin
        logic [dlp_pkg::TERM_W+PW-1:0] prod;
        for (int i = 0; i < dlp_pkg::LANES; i++)
        begin
            prod       = lane_in[i].term * lane_in[i].f;
            p1_next[i] = prod[2*PW-1:PW];
        end
    end

    always_comb
    begin
        logic [dlp_pkg::TERM_W+PW-1:0] prod;
        for (int i = 0; i < dlp_pkg::LANES; i++)
        begin
            prod       = p1_reg[i] * recip;
            q0_next[i] = prod[dlp_pkg::TERM_W+PW-1:dlp_pkg::TERM_W];
        end
    end

    always_comb
    begin
        logic [PW+dlp_pkg::K_W-1:0] kq;
        logic [PW+dlp_pkg::K_W-1:0] rem;
        logic [PW-1:0]              q;
        for (int i = 0; i < dlp_pkg::LANES; i++)
        begin
            kq  = q0_reg[i] * k_in;
            rem = {{dlp_pkg::K_W{1'b0}}, p2_reg[i]} - kq;
            q   = q0_reg[i] + PW'(rem >= {{PW{1'b0}}, k_in});
            lane3_next[i]      = lane2_reg[i];
            lane3_next[i].term = {1'b0, q};
            lane3_next[i].sum  = lane2_reg[i].sum + dlp_pkg::SUM_W'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lane1_reg <= lane_in;
        p1_reg    <= p1_next;
        lane2_reg <= lane1_reg;
        p2_reg    <= p1_reg;
        q0_reg    <= q0_next;
        lane3_reg <= lane3_next;
    end

    assign ctl_out  = ctl3_reg;
    assign lane_out = lane3_reg;
endmodule

@@ hw/rtl/dlp_recip_cell.sv @@
`timescale 1ns / 1ps
// One restoring division step of the all-ones word by the Taylor sum, both lanes
module dlp_recip_cell (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  dlp_pkg::dlp_ctl_t                             ctl_in,
    input  dlp_pkg::dlp_rcp_t [dlp_pkg::LANES-1:0]        lane_in,
    output dlp_pkg::dlp_ctl_t                             ctl_out,
    output dlp_pkg::dlp_rcp_t [dlp_pkg::LANES-1:0]        lane_out
);
    dlp_pkg::dlp_ctl_t                       ctl_reg;
    dlp_pkg::dlp_rcp_t [dlp_pkg::LANES-1:0]  lane_reg;
    dlp_pkg::dlp_rcp_t [dlp_pkg::LANES-1:0]  lane_next;

    always_comb
    begin
        logic [dlp_pkg::SUM_W:0] trial;
        for (int i = 0; i < dlp_pkg::LANES; i++)
        begin
            trial        = {lane_in[i].rem, 1'b1};
            lane_next[i] = lane_in[i];
            if (trial >= {1'b0, lane_in[i].sum})
            begin
                lane_next[i].rem = dlp_pkg::SUM_W'(trial - {1'b0, lane_in[i].sum});
                lane_next[i].q   = {lane_in[i].q[dlp_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                lane_next[i].rem = trial[dlp_pkg::SUM_W-1:0];
                lane_next[i].q   = {lane_in[i].q[dlp_pkg::FRAC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign ctl_out  = ctl_reg;
    assign lane_out = lane_reg;
endmodule

@@ hw/rtl/dlp_pow_cell.sv @@
`timescale 1ns / 1ps
// One conditional multiply by exp(-1) with half-up rounding, both lanes
module dlp_pow_cell (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [dlp_pkg::EXP_N_W-1:0]                   idx_in,
    input  dlp_pkg::dlp_ctl_t                             ctl_in,
    input  dlp_pkg::dlp_pow_t [dlp_pkg::LANES-1:0]        lane_in,
    output dlp_pkg::dlp_ctl_t                             ctl_out,
    output dlp_pkg::dlp_pow_t [dlp_pkg::LANES-1:0]        lane_out
);
    localparam int unsigned PW = dlp_pkg::FRAC_W;

    dlp_pkg::dlp_ctl_t                       ctl_reg;
    dlp_pkg::dlp_pow_t [dlp_pkg::LANES-1:0]  lane_reg;
    dlp_pkg::dlp_pow_t [dlp_pkg::LANES-1:0]  lane_next;

    always_comb
    begin
        logic [2*PW-1:0] prod;
        for (int i = 0; i < dlp_pkg::LANES; i++)
        begin
            prod         = lane_in[i].e * dlp_pkg::EXPM1_Q32
                           + {{PW{1'b0}}, 1'b1, {(PW-1){1'b0}}};
            lane_next[i] = lane_in[i];
            if (idx_in < lane_in[i].n)
            begin
                lane_next[i].e = prod[2*PW-1:PW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign ctl_out  = ctl_reg;
    assign lane_out = lane_reg;
endmodule

@@ hw/rtl/discrete_laplace_probability.sv @@
`timescale 1ns / 1ps
// Top level of the discrete Laplace probability block
//
// Gives the probability, unsigned Q1.16, of a signed prediction error under a
// discretized Laplace law whose standard deviation (unsigned Q8.8) sits in std_dev.
// Input: pulse start with symbol_error; the item transfers at a rising edge with
// start high and busy low. busy stays low, so an item may enter in every cycle.
// Output: done is high for one cycle with probability and out_of_range; the result
// transfers at the edge that ends that cycle and cannot be held off.
// Configuration: cfg_wdata is written to std_dev at an edge with cfg_valid and
// cfg_ready high; cfg_ready stays high. Write only while no item is in flight.
// Throughput: one item per cycle. The cell row holds 49 argument division steps,
// 14 Taylor terms of 3 stages each, 32 reciprocal division steps, 23 exp(-1) steps,
// plus one input and one output register.
// Reset: asynchronous, clears every valid bit in the row and sets std_dev to 1.0;
// items in flight are dropped.
`include "discrete_laplace_probability_macros.svh"
module discrete_laplace_probability (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [dlp_pkg::ERR_W-1:0]   symbol_error,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dlp_pkg::SD_W-1:0]           cfg_wdata,
    output logic                               done,
    output logic [dlp_pkg::PROB_W-1:0]         probability,
    output logic                               out_of_range
);
    localparam int unsigned L  = dlp_pkg::LANES;
    localparam int unsigned FW = dlp_pkg::FRAC_W;

    logic [dlp_pkg::SD_W-1:0]                std_dev_reg;
    logic [dlp_pkg::SD_W-1:0]                std_dev_next;

    logic [dlp_pkg::MAG_W-1:0]               raw;
    logic [dlp_pkg::MAG_W-1:0]               mag;
    logic [dlp_pkg::MULT_W-1:0]              mult_a;
    logic [dlp_pkg::MULT_W-1:0]              mult_b;
    logic [dlp_pkg::MULT_W+dlp_pkg::SQRT2_W-1:0] prod_a;
    logic [dlp_pkg::MULT_W+dlp_pkg::SQRT2_W-1:0] prod_b;
    dlp_pkg::dlp_ctl_t                       ctl0_reg;
    dlp_pkg::dlp_ctl_t                       ctl0_next;
    logic [dlp_pkg::SD_W-1:0]                sd0_reg;
    dlp_pkg::dlp_div_t [L-1:0]               lane0_reg;
    dlp_pkg::dlp_div_t [L-1:0]               lane0_next;

    dlp_pkg::dlp_ctl_t                       q_ctl  [dlp_pkg::QUOT_CELLS+1];
    logic [dlp_pkg::SD_W-1:0]                q_sd   [dlp_pkg::QUOT_CELLS+1];
    dlp_pkg::dlp_div_t [L-1:0]               q_lane [dlp_pkg::QUOT_CELLS+1];
    dlp_pkg::dlp_ctl_t                       t_ctl  [dlp_pkg::TAYLOR_TERMS+1];
    dlp_pkg::dlp_tay_t [L-1:0]               t_lane [dlp_pkg::TAYLOR_TERMS+1];
    dlp_pkg::dlp_ctl_t                       r_ctl  [dlp_pkg::RECIP_CELLS+1];
    dlp_pkg::dlp_rcp_t [L-1:0]               r_lane [dlp_pkg::RECIP_CELLS+1];
    dlp_pkg::dlp_ctl_t                       p_ctl  [dlp_pkg::POW_CELLS+1];
    dlp_pkg::dlp_pow_t [L-1:0]               p_lane [dlp_pkg::POW_CELLS+1];

    dlp_pkg::dlp_ctl_t                       fin_ctl;
    logic [FW-1:0]                           exp_a;
    logic [FW-1:0]                           exp_b;
    logic [FW-1:0]                           diff;
    logic [FW:0]                             rnd_zero;
    logic [FW:0]                             rnd_tail;
    logic [FW:0]                             rnd_mid;
    logic [dlp_pkg::PROB_W-1:0]              prob_next;
    logic                                    done_reg;
    logic [dlp_pkg::PROB_W-1:0]              probability_reg;
    logic                                    oor_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign std_dev_next = (cfg_valid && cfg_ready) ? cfg_wdata : std_dev_reg;

    always_comb
    begin
        raw    = $unsigned(symbol_error);
        mag    = raw[dlp_pkg::MAG_W-1] ? (~raw + dlp_pkg::MAG_W'(1)) : raw;
        mult_a = (mag == '0) ? dlp_pkg::MULT_W'(1) : ({mag, 1'b0} - dlp_pkg::MULT_W'(1));
        mult_b = {mag, 1'b0} + dlp_pkg::MULT_W'(1);
        prod_a = mult_a * dlp_pkg::SQRT2_Q32;
        prod_b = mult_b * dlp_pkg::SQRT2_Q32;

        ctl0_next.valid  = start && !busy;
        ctl0_next.oor    = mag > dlp_pkg::MAG_W'(dlp_pkg::MAX_ERROR);
        ctl0_next.s_zero = std_dev_reg == '0;
        ctl0_next.a_zero = mag == '0;
        ctl0_next.a_max  = mag == dlp_pkg::MAG_W'(dlp_pkg::MAX_ERROR);

        lane0_next[0].rem = '0;
        lane0_next[0].nq  = dlp_pkg::NUM_W'({prod_a, 7'd0});
        lane0_next[1].rem = '0;
        lane0_next[1].nq  = dlp_pkg::NUM_W'({prod_b, 7'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            std_dev_reg <= dlp_pkg::STD_DEV_RESET;
            ctl0_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            std_dev_reg <= std_dev_next;
            ctl0_reg    <= ctl0_next;
            done_reg    <= fin_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sd0_reg         <= std_dev_reg;
        lane0_reg       <= lane0_next;
        probability_reg <= prob_next;
        oor_reg         <= fin_ctl.oor;
    end

    assign q_ctl[0]  = ctl0_reg;
    assign q_sd[0]   = sd0_reg;
    assign q_lane[0] = lane0_reg;

    for (genvar g = 0; g < dlp_pkg::QUOT_CELLS; g++)
    begin : g_quot
        dlp_quot_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (q_ctl[g]),
            .sd_in    (q_sd[g]),
            .lane_in  (q_lane[g]),
            .ctl_out  (q_ctl[g+1]),
            .sd_out   (q_sd[g+1]),
            .lane_out (q_lane[g+1])
        );
    end

    assign t_ctl[0] = q_ctl[dlp_pkg::QUOT_CELLS];

    for (genvar i = 0; i < L; i++)
    begin : g_to_taylor
        assign t_lane[0][i].term = {1'b1, {FW{1'b0}}};
        assign t_lane[0][i].sum  = {2'b01, {FW{1'b0}}};
        assign t_lane[0][i].f    = q_lane[dlp_pkg::QUOT_CELLS][i].nq[FW-1:0];
        assign t_lane[0][i].n    = q_lane[dlp_pkg::QUOT_CELLS][i].nq[FW+dlp_pkg::EXP_N_W-1:FW];
        assign t_lane[0][i].z    = q_lane[dlp_pkg::QUOT_CELLS][i].nq[dlp_pkg::NUM_W-1:FW]
                                   > dlp_pkg::INT_W'(dlp_pkg::EXP_N_MAX);
    end

    for (genvar g = 0; g < dlp_pkg::TAYLOR_TERMS; g++)
    begin : g_taylor
        dlp_taylor_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .k_in     (dlp_pkg::K_W'(g + 1)),
            .ctl_in   (t_ctl[g]),
            .lane_in  (t_lane[g]),
            .ctl_out  (t_ctl[g+1]),
            .lane_out (t_lane[g+1])
        );
    end

    assign r_ctl[0] = t_ctl[dlp_pkg::TAYLOR_TERMS];

    for (genvar i = 0; i < L; i++)
    begin : g_to_recip
        assign r_lane[0][i].rem = {2'b00, {FW{1'b1}}};
        assign r_lane[0][i].sum = t_lane[dlp_pkg::TAYLOR_TERMS][i].sum;
        assign r_lane[0][i].q   = '0;
        assign r_lane[0][i].n   = t_lane[dlp_pkg::TAYLOR_TERMS][i].n;
        assign r_lane[0][i].z   = t_lane[dlp_pkg::TAYLOR_TERMS][i].z;
    end

    for (genvar g = 0; g < dlp_pkg::RECIP_CELLS; g++)
    begin : g_recip
        dlp_recip_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (r_ctl[g]),
            .lane_in  (r_lane[g]),
            .ctl_out  (r_ctl[g+1]),
            .lane_out (r_lane[g+1])
        );
    end

    assign p_ctl[0] = r_ctl[dlp_pkg::RECIP_CELLS];

    for (genvar i = 0; i < L; i++)
    begin : g_to_pow
        assign p_lane[0][i].e = r_lane[dlp_pkg::RECIP_CELLS][i].q;
        assign p_lane[0][i].n = r_lane[dlp_pkg::RECIP_CELLS][i].n;
        assign p_lane[0][i].z = r_lane[dlp_pkg::RECIP_CELLS][i].z;
    end

    for (genvar g = 0; g < dlp_pkg::POW_CELLS; g++)
    begin : g_pow
        dlp_pow_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx_in   (dlp_pkg::EXP_N_W'(g)),
            .ctl_in   (p_ctl[g]),
            .lane_in  (p_lane[g]),
            .ctl_out  (p_ctl[g+1]),
            .lane_out (p_lane[g+1])
        );
    end

    assign fin_ctl = p_ctl[dlp_pkg::POW_CELLS];
    assign exp_a   = p_lane[dlp_pkg::POW_CELLS][0].z ? '0 : p_lane[dlp_pkg::POW_CELLS][0].e;
    assign exp_b   = p_lane[dlp_pkg::POW_CELLS][1].z ? '0 : p_lane[dlp_pkg::POW_CELLS][1].e;
    assign diff    = (exp_b > exp_a) ? '0 : (exp_a - exp_b);

    assign rnd_zero = ({1'b0, exp_a} + (FW+1)'(32'h0000_8000)) >> 16;
    assign rnd_tail = ({1'b0, exp_a} + (FW+1)'(32'h0001_0000)) >> 17;
    assign rnd_mid  = ({1'b0, diff}  + (FW+1)'(32'h0001_0000)) >> 17;

    always_comb
    begin
        priority if (fin_ctl.oor)
        begin
            prob_next = '0;
        end
        else if (fin_ctl.s_zero)
        begin
            prob_next = fin_ctl.a_zero ? dlp_pkg::PROB_ONE : '0;
        end
        else if (fin_ctl.a_zero)
        begin
            prob_next = (rnd_zero >= (FW+1)'(dlp_pkg::PROB_ONE)) ? '0
                      : dlp_pkg::PROB_ONE - rnd_zero[dlp_pkg::PROB_W-1:0];
        end
        else if (fin_ctl.a_max)
        begin
            prob_next = (rnd_tail > (FW+1)'(dlp_pkg::PROB_ONE)) ? dlp_pkg::PROB_ONE
                      : rnd_tail[dlp_pkg::PROB_W-1:0];
        end
        else
        begin
            prob_next = (rnd_mid > (FW+1)'(dlp_pkg::PROB_ONE)) ? dlp_pkg::PROB_ONE
                      : rnd_mid[dlp_pkg::PROB_W-1:0];
        end
    end

    assign done         = done_reg;
    assign probability  = probability_reg;
    assign out_of_range = oor_reg;

    `DLP_ASSERT_IMPLY(a_prob_range, clk, rst_n, done_reg, probability_reg <= dlp_pkg::PROB_ONE)
    `DLP_ASSERT_IMPLY(a_oor_zero, clk, rst_n, done_reg && oor_reg, probability_reg == '0)
    `DLP_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_valid && cfg_ready, std_dev_reg == $past(cfg_wdata))
    `DLP_ASSERT_NEXT(a_delta_off, clk, rst_n, fin_ctl.valid && fin_ctl.s_zero && !fin_ctl.a_zero, done_reg && probability_reg == '0)
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for discrete_laplace_probability: directed and random errors per deviation
module tb;
    localparam int unsigned LATENCY = 148;
    localparam int unsigned SETTLE = LATENCY + 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [63:0] SQRT2_FIX = 64'd6074001000;
    localparam logic [63:0] EXPM1_FIX = 64'd1580030169;
    localparam logic [63:0] ONE_FIX = 64'd4294967296;

    typedef struct packed {
        logic [dlp_pkg::PROB_W-1:0] prob;
        logic                       oor;
    } laplace_result_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic signed [dlp_pkg::ERR_W-1:0]   symbol_error;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [dlp_pkg::SD_W-1:0]           cfg_wdata;
    logic                               done;
    logic [dlp_pkg::PROB_W-1:0]         probability;
    logic                               out_of_range;

    laplace_result_t          pending_probs[$];
    logic [dlp_pkg::SD_W-1:0] dev_shadow;
    int unsigned              fail_count;
    int unsigned              cycle_count;
    bit                       allow_gaps;

    discrete_laplace_probability uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .symbol_error (symbol_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .probability  (probability),
        .out_of_range (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] neg_exp(input logic [63:0] x);
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        n = x >> 32;
        f = x & 64'hFFFF_FFFF;
        if (n > 64'd23)
            return 64'd0;
        term = ONE_FIX;
        sum = ONE_FIX;
        for (int k = 1; k <= 14; k++)
        begin
            term = ((term * f) >> 32) / 64'(k);
            sum += term;
        end
        e = 64'hFFFF_FFFF_FFFF_FFFF / sum;
        for (int k = 0; k < int'(n); k++)
            e = (e * EXPM1_FIX + 64'h8000_0000) >> 32;
        return e;
    endfunction

    function automatic logic [63:0] half_exp(input logic [63:0] m,
                                             input logic [dlp_pkg::SD_W-1:0] s);
        return neg_exp((m * 64'd128 * SQRT2_FIX) / 64'(s));
    endfunction

    function automatic laplace_result_t laplace_prob(input logic [dlp_pkg::ERR_W-1:0] d,
                                                     input logic [dlp_pkg::SD_W-1:0] s);
        laplace_result_t r;
        logic [63:0] mag;
        logic [63:0] ea;
        logic [63:0] eb;
        logic [63:0] p;
        mag = d[dlp_pkg::ERR_W-1] ? 64'(10'h200 - {1'b0, d}) : 64'(d);
        p = 0;
        r.oor = 1'b0;
        if (mag > 64'(dlp_pkg::MAX_ERROR))
            r.oor = 1'b1;
        else if (s == 0)
            p = (mag == 0) ? 64'd65536 : 64'd0;
        else if (mag == 0)
        begin
            ea = (half_exp(64'd1, s) + 64'h8000) >> 16;
            p = (ea >= 64'd65536) ? 64'd0 : 64'd65536 - ea;
        end
        else
        begin
            ea = half_exp(2 * mag - 1, s);
            if (mag < 64'(dlp_pkg::MAX_ERROR))
            begin
                eb = half_exp(2 * mag + 1, s);
                p = (((eb > ea) ? 64'd0 : ea - eb) + 64'h1_0000) >> 17;
            end
            else
                p = (ea + 64'h1_0000) >> 17;
        end
        if (p > 64'd65536)
            p = 64'd65536;
        r.prob = p[dlp_pkg::PROB_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        laplace_result_t want;
        if (rst_n && done)
        begin
            if (pending_probs.size() == 0)
            begin
                $error("unexpected result: probability %0d out_of_range %0b",
                       probability, out_of_range);
                fail_count++;
            end
            else
            begin
                want = pending_probs.pop_front();
                if (probability !== want.prob)
                begin
                    $error("probability: expected %0d actual %0d", want.prob, probability);
                    fail_count++;
                end
                if (out_of_range !== want.oor)
                begin
                    $error("out_of_range: expected %0b actual %0b", want.oor, out_of_range);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("discrete_laplace_probability regression: fail");
                $finish;
            end
        end
    end

    task automatic idle_burst();
        start = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    task automatic send_error(input logic [dlp_pkg::ERR_W-1:0] d);
        if (allow_gaps && $urandom_range(0, 4) == 0)
            idle_burst();
        start = 1'b1;
        symbol_error = d;
        do @(posedge clk); while (busy);
        pending_probs.push_back(laplace_prob(d, dev_shadow));
        @(negedge clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending_probs.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_std_dev(input logic [dlp_pkg::SD_W-1:0] s);
        drain();
        cfg_valid = 1'b1;
        cfg_wdata = s;
        do @(posedge clk); while (!cfg_ready);
        dev_shadow = s;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_wdata = dlp_pkg::SD_W'($urandom());
    endtask

    task automatic random_error();
        if ($urandom_range(0, 3) == 0)
            send_error(dlp_pkg::ERR_W'($urandom_range(0, 511)));
        else
            send_error(dlp_pkg::ERR_W'($signed($urandom_range(0, 40)) - 20));
    endtask

    task automatic test_reset_deviation();
        int edge_vals[] = '{0, 1, -1, 2, -2, 127, -128, 254, -254, 255, -255, -256};
        foreach (edge_vals[i])
            send_error(dlp_pkg::ERR_W'(edge_vals[i]));
    endtask

    task automatic test_zero_deviation();
        write_std_dev(16'd0);
        send_error(9'd0);
        send_error(9'd1);
        send_error(-9'sd1);
        send_error(9'd255);
        send_error(9'h100);
    endtask

    task automatic test_deviation_extremes();
        write_std_dev(16'd65535);
        send_error(9'd0);
        send_error(9'd1);
        send_error(9'd255);
        send_error(-9'sd255);
        write_std_dev(16'd1);
        send_error(9'd0);
        send_error(9'd1);
        send_error(-9'sd255);
    endtask

    task automatic test_random_deviations();
        logic [dlp_pkg::SD_W-1:0] devs[] = '{16'd256, 16'd1, 16'd65535, 16'd0};
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < devs.size())
                write_std_dev(devs[phase]);
            else if (phase % 2 == 0)
                write_std_dev(dlp_pkg::SD_W'($urandom_range(16, 4096)));
            else
                write_std_dev(dlp_pkg::SD_W'($urandom()));
            allow_gaps = (phase < 10);
            for (int i = 0; i < 100; i++)
            begin
                random_error();
                if (i == 50 && phase == 5)
                    drain();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        symbol_error = '0;
        cfg_valid = 1'b0;
        cfg_wdata = '0;
        fail_count = 0;
        allow_gaps = 1'b1;
        dev_shadow = dlp_pkg::STD_DEV_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_deviation();
        test_zero_deviation();
        test_deviation_extremes();
        test_random_deviations();
        drain();
        if (fail_count == 0)
            $display("discrete_laplace_probability regression: pass");
        else
            $display("discrete_laplace_probability regression: fail");
        $finish;
    end
endmodule
